FILE: sv/li_chao_max_line_tree_top_defines.svh
// Assertion macros shared by the RTL files.
`ifndef LI_CHAO_MAX_LINE_TREE_TOP_DEFINES_SVH
`define LI_CHAO_MAX_LINE_TREE_TOP_DEFINES_SVH

// Checks that a condition implies a consequence at the same edge.
`define LC_ASSERT_IMP(label, clk, rst_n, cond, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
	else $error("assertion failed");

// Checks that a condition implies a consequence at the next edge.
`define LC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
	else $error("assertion failed");

`endif

FILE: sv/lcmlt_pkg.sv
package lcmlt_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int SLOPE_W = 16;
	localparam int ICPT_W = 32;
	localparam int VALUE_W = 48;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_READ  = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_EVAL  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [SLOPE_W-1:0] slope;
		logic [ICPT_W-1:0] icpt;
	} line_t;

	function automatic logic signed [VALUE_W-1:0] add_icpt(
		input logic signed [VALUE_W-1:0] prod,
		input logic [ICPT_W-1:0] c
	);
		logic signed [VALUE_W-1:0] ext;
		begin
			ext = VALUE_W'(signed'(c));
			add_icpt = prod + ext;
		end
	endfunction

endpackage

FILE: sv/lcmlt_store.sv
`include "li_chao_max_line_tree_top_defines.svh"

module lcmlt_store #(
	parameter int AW = 11
) (
	input  logic clk,
	input  logic arst_n,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  lcmlt_pkg::line_t wline,
	input  logic wpres,
	input  logic [AW-1:0] raddr,
	output lcmlt_pkg::line_t rline,
	output logic rpres
);

	lcmlt_pkg::line_t mem_line [2**AW];
	logic mem_pres [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_line[waddr] <= wline;
			mem_pres[waddr] <= wpres;
		end
		rline <= mem_line[raddr];
		rpres <= mem_pres[raddr];
	end

	`LC_ASSERT_IMP(a_waddr_known, clk, arst_n, we, !$isunknown(waddr))

endmodule

FILE: sv/li_chao_max_line_tree_top.sv
// Insert walks one tree level per pass through READ, MUL and EVAL, up to log2(DOMAIN_SIZE)+1 levels.
// Query walks the levels the same way and returns its result with a one-cycle done strobe.
// Each level is one memory read, one registered multiply and one compare.
// After reset a clearing pass over all 2*DOMAIN_SIZE nodes holds busy high.
// The receiver cannot stall; one operation is in flight at a time.
`include "li_chao_max_line_tree_top_defines.svh"

module li_chao_max_line_tree_top #(
	parameter int DOMAIN_SIZE = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic signed [15:0] cfg_wdata,
	input  logic start,
	output logic busy,
	input  logic operation,
	input  logic signed [15:0] slope,
	input  logic signed [31:0] intercept,
	input  logic [9:0] position,
	output logic done,
	output logic signed [47:0] max_value,
	output logic empty_res
);

	localparam int AW = $clog2(2 * DOMAIN_SIZE);
	localparam int PW = $clog2(DOMAIN_SIZE + 1);
	localparam int XW = PW + 18;
	localparam int VW = lcmlt_pkg::VALUE_W;

	lcmlt_pkg::state_t state_q;
	logic signed [15:0] origin_q;
	logic op_q;
	lcmlt_pkg::line_t cur_q;
	logic [AW-1:0] node_q;
	logic [PW-1:0] lo_q, hi_q, pos_q;
	logic have_q;
	logic signed [VW-1:0] best_q;
	logic signed [VW-1:0] pn_m_q, pc_m_q, pn_l_q, pc_l_q;
	logic [AW-1:0] clr_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	lcmlt_pkg::line_t wline, rline;
	logic wpres, rpres;

	lcmlt_store #(.AW(AW)) u_store (
		.clk(clk), .arst_n(arst_n), .we(we), .waddr(waddr), .wline(wline),
		.wpres(wpres), .raddr(raddr), .rline(rline), .rpres(rpres)
	);

	logic [PW-1:0] mid, pos_in;
	logic signed [XW-1:0] xm, xl;
	logic signed [VW-1:0] vn_m, vc_m, vn_l, vc_l, vq;
	logic new_wins, loser_left, leaf;
	lcmlt_pkg::line_t loser;

	assign mid = lo_q + PW'((hi_q - lo_q) >> 1);
	assign leaf = (hi_q - lo_q) <= PW'(1);
	assign xm = XW'(origin_q) + XW'(signed'({1'b0, (op_q ? pos_q : mid)}));
	assign xl = XW'(origin_q) + XW'(signed'({1'b0, lo_q}));
	assign pos_in = (32'(position) > 32'(DOMAIN_SIZE - 1)) ? PW'(DOMAIN_SIZE - 1)
		: PW'(position);

	assign vn_m = lcmlt_pkg::add_icpt(pn_m_q, cur_q.icpt);
	assign vc_m = lcmlt_pkg::add_icpt(pc_m_q, rline.icpt);
	assign new_wins = vn_m > vc_m;
	assign loser = new_wins ? rline : cur_q;
	assign vn_l = lcmlt_pkg::add_icpt(pn_l_q, cur_q.icpt);
	assign vc_l = lcmlt_pkg::add_icpt(pc_l_q, rline.icpt);
	assign loser_left = new_wins ? (vc_l > vn_l) : (vn_l > vc_l);
	assign vq = vc_m;

	assign busy = state_q != lcmlt_pkg::ST_IDLE;
	assign raddr = node_q;

	always_comb begin
		we = 1'b0;
		waddr = node_q;
		wline = cur_q;
		wpres = 1'b1;
		if (state_q == lcmlt_pkg::ST_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
			wpres = 1'b0;
		end else if (state_q == lcmlt_pkg::ST_EVAL && op_q == lcmlt_pkg::OP_INSERT) begin
			we = !rpres || new_wins;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcmlt_pkg::ST_CLEAR;
			origin_q <= '0;
			clr_q <= '0;
			done <= 1'b0;
		end else begin
			done <= state_q == lcmlt_pkg::ST_EVAL && op_q == lcmlt_pkg::OP_QUERY
				&& (!rpres || leaf);
			if (cfg_we) begin
				origin_q <= cfg_wdata;
			end
			unique case (state_q)
				lcmlt_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(2 * DOMAIN_SIZE - 1)) begin
						state_q <= lcmlt_pkg::ST_IDLE;
					end
				end
				lcmlt_pkg::ST_IDLE: begin
					if (start) begin
						state_q <= lcmlt_pkg::ST_READ;
					end
				end
				lcmlt_pkg::ST_READ: state_q <= lcmlt_pkg::ST_MUL;
				lcmlt_pkg::ST_MUL: state_q <= lcmlt_pkg::ST_EVAL;
				lcmlt_pkg::ST_EVAL: begin
					if (!rpres || leaf) begin
						state_q <= lcmlt_pkg::ST_IDLE;
					end else begin
						state_q <= lcmlt_pkg::ST_READ;
					end
				end
				default: state_q <= lcmlt_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lcmlt_pkg::ST_IDLE && start) begin
			op_q <= operation;
			cur_q <= '{slope: slope, icpt: intercept};
			pos_q <= pos_in;
			node_q <= '0;
			lo_q <= '0;
			hi_q <= PW'(DOMAIN_SIZE);
			have_q <= 1'b0;
			best_q <= '0;
		end
		if (state_q == lcmlt_pkg::ST_MUL) begin
			pn_m_q <= VW'(signed'(cur_q.slope)) * VW'(xm);
			pc_m_q <= VW'(signed'(rline.slope)) * VW'(xm);
			pn_l_q <= VW'(signed'(cur_q.slope)) * VW'(xl);
			pc_l_q <= VW'(signed'(rline.slope)) * VW'(xl);
		end
		if (state_q == lcmlt_pkg::ST_EVAL) begin
			if (op_q == lcmlt_pkg::OP_INSERT) begin
				cur_q <= loser;
				if (loser_left) begin
					node_q <= node_q + AW'(1);
					hi_q <= mid;
				end else begin
					node_q <= node_q + AW'(2 * (mid - lo_q));
					lo_q <= mid;
				end
			end else begin
				if (rpres && (!have_q || vq > best_q)) begin
					best_q <= vq;
					have_q <= 1'b1;
				end
				if (pos_q < mid) begin
					node_q <= node_q + AW'(1);
					hi_q <= mid;
				end else begin
					node_q <= node_q + AW'(2 * (mid - lo_q));
					lo_q <= mid;
				end
			end
		end
	end

	always_comb begin
		empty_res = !have_q;
		max_value = have_q ? best_q : '0;
		if (rpres && (!have_q || vq > best_q)) begin
			empty_res = 1'b0;
			max_value = vq;
		end
	end

	logic done_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_d <= 1'b0;
		end else begin
			done_d <= state_q == lcmlt_pkg::ST_EVAL && op_q == lcmlt_pkg::OP_QUERY
				&& (!rpres || leaf);
		end
	end

	`LC_ASSERT_IMP(a_done_match, clk, arst_n, done, done_d)
	`LC_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`LC_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)

endmodule

FILE: sim/li_chao_max_line_tree_checker.sv
module li_chao_max_line_tree_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic signed [15:0] cfg_wdata,
	input  logic start,
	input  logic busy,
	input  logic operation,
	input  logic signed [15:0] slope,
	input  logic signed [31:0] intercept,
	input  logic [9:0] position,
	input  logic done,
	input  logic signed [47:0] max_value,
	input  logic empty_res,
	output int fails,
	output int pending
);

	localparam int SPAN = 1024;
	localparam int NODES = 2 * SPAN;

	typedef struct {
		logic signed [47:0] value;
		logic empty;
	} max_result_t;

	logic signed [15:0] tree_slope [NODES];
	logic signed [31:0] tree_icpt [NODES];
	bit tree_used [NODES];
	longint origin;
	max_result_t max_results_due[$];

	assign pending = max_results_due.size();

	function automatic longint line_value(logic signed [15:0] s, logic signed [31:0] c,
		longint x);
		return longint'(s) * x + longint'(c);
	endfunction

	task automatic add_line(logic signed [15:0] s_in, logic signed [31:0] c_in);
		int node;
		int lo;
		int hi;
		int mid;
		logic signed [15:0] s;
		logic signed [31:0] c;
		logic signed [15:0] ks;
		logic signed [31:0] kc;
		node = 0;
		lo = 0;
		hi = SPAN;
		s = s_in;
		c = c_in;
		while (node < NODES) begin
			if (!tree_used[node]) begin
				tree_slope[node] = s;
				tree_icpt[node] = c;
				tree_used[node] = 1'b1;
				return;
			end
			ks = tree_slope[node];
			kc = tree_icpt[node];
			mid = lo + (hi - lo) / 2;
			if (line_value(s, c, origin + mid) > line_value(ks, kc, origin + mid)) begin
				tree_slope[node] = s;
				tree_icpt[node] = c;
				s = ks;
				c = kc;
				ks = tree_slope[node];
				kc = tree_icpt[node];
			end
			if (hi - lo <= 1)
				return;
			if (line_value(s, c, origin + lo) > line_value(ks, kc, origin + lo)) begin
				node = node + 1;
				hi = mid;
			end else begin
				node = node + 2 * (mid - lo);
				lo = mid;
			end
		end
	endtask

	function automatic max_result_t max_at(int p);
		max_result_t r;
		int node;
		int lo;
		int hi;
		int mid;
		longint v;
		longint best;
		bit have;
		node = 0;
		lo = 0;
		hi = SPAN;
		have = 0;
		best = 0;
		while (node < NODES && tree_used[node]) begin
			v = line_value(tree_slope[node], tree_icpt[node], origin + p);
			if (!have || v > best) begin
				best = v;
				have = 1;
			end
			if (hi - lo <= 1)
				break;
			mid = lo + (hi - lo) / 2;
			if (p < mid) begin
				node = node + 1;
				hi = mid;
			end else begin
				node = node + 2 * (mid - lo);
				lo = mid;
			end
		end
		r.value = have ? best[47:0] : '0;
		r.empty = !have;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		max_result_t exp_r;
		if (!arst_n) begin
			foreach (tree_used[i])
				tree_used[i] = 0;
			origin = 0;
			fails = 0;
			max_results_due.delete();
		end else begin
			if (done) begin
				if (max_results_due.size() == 0) begin
					$error("result with no query outstanding");
					fails++;
				end else begin
					exp_r = max_results_due.pop_front();
					if (max_value !== exp_r.value) begin
						$error("max_value: expected %0d, actual %0d", exp_r.value, max_value);
						fails++;
					end
					if (empty_res !== exp_r.empty) begin
						$error("empty_res: expected %0b, actual %0b", exp_r.empty, empty_res);
						fails++;
					end
				end
			end
			if (cfg_we)
				origin = longint'(cfg_wdata);
			if (start && !busy) begin
				if (operation == lcmlt_pkg::OP_INSERT)
					add_line(slope, intercept);
				else
					max_results_due.push_back(max_at(int'(position)));
			end
		end
	end
endmodule

FILE: sim/tb_li_chao_max_line_tree_top.sv
module tb_li_chao_max_line_tree_top;

	localparam int ITEMS_PER_PHASE = 210;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic signed [15:0] cfg_wdata = '0;
	logic start = 0;
	logic busy;
	logic operation = lcmlt_pkg::OP_INSERT;
	logic signed [15:0] slope = '0;
	logic signed [31:0] intercept = '0;
	logic [9:0] position = '0;
	logic done;
	logic signed [47:0] max_value;
	logic empty_res;
	int fails;
	int pending;
	int quiet_cycles = 0;
	bit gaps_on = 1;

	always #6 clk = ~clk;

	li_chao_max_line_tree_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .operation(operation), .slope(slope),
		.intercept(intercept), .position(position), .done(done),
		.max_value(max_value), .empty_res(empty_res)
	);

	li_chao_max_line_tree_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy), .operation(operation), .slope(slope),
		.intercept(intercept), .position(position), .done(done),
		.max_value(max_value), .empty_res(empty_res), .fails(fails), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic issue(logic op, logic signed [15:0] s, logic signed [31:0] c,
		logic [9:0] p);
		int gap;
		operation = op;
		slope = s;
		intercept = c;
		position = p;
		start = 1;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			start = 0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_origin(logic signed [15:0] v);
		start = 0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_wdata = v;
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic logic signed [15:0] pick_slope();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($urandom_range(0, 64) - 32);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 4096) - 2048);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_icpt();
		case ($urandom_range(0, 2))
			0: return $urandom();
			1: return $urandom_range(0, 200000) - 100000;
			default: return $urandom_range(0, 8000000) - 4000000;
		endcase
	endfunction

	task automatic random_items(int n);
		logic [9:0] p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
				: 10'($urandom());
			if ($urandom_range(0, 1))
				issue(lcmlt_pkg::OP_INSERT, pick_slope(), pick_icpt(), p);
			else
				issue(lcmlt_pkg::OP_QUERY, pick_slope(), pick_icpt(), p);
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		issue(lcmlt_pkg::OP_QUERY, 16'sh7fff, 32'sh7fffffff, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, 16'sh8000, 32'sh80000000, 10'd1023);
		issue(lcmlt_pkg::OP_INSERT, 16'sd0, 32'sd100, 10'd1023);
		issue(lcmlt_pkg::OP_INSERT, 16'sd0, 32'sd100, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd512);
		issue(lcmlt_pkg::OP_INSERT, 16'sh7fff, 32'sh80000000, 10'd5);
		issue(lcmlt_pkg::OP_INSERT, 16'sh8000, 32'sh7fffffff, 10'd700);
		issue(lcmlt_pkg::OP_INSERT, 16'sh8000, 32'sh80000000, 10'd0);
		issue(lcmlt_pkg::OP_INSERT, 16'sh7fff, 32'sh7fffffff, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, 16'sh1234, 32'sh5678, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd1);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd511);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd1023);
		write_origin(16'sh8000);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd0);
		issue(lcmlt_pkg::OP_INSERT, 16'sd256, 32'sd0, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd1023);
		write_origin(16'sh7fff);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd0);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd1023);
		issue(lcmlt_pkg::OP_INSERT, 16'sh8000, 32'sh7fffffff, 10'd3);
		issue(lcmlt_pkg::OP_QUERY, '0, '0, 10'd300);

		random_items(ITEMS_PER_PHASE);
		write_origin(16'sh8000);
		random_items(ITEMS_PER_PHASE);
		write_origin(16'($urandom()));
		random_items(ITEMS_PER_PHASE);
		write_origin(16'sh0);
		random_items(ITEMS_PER_PHASE);
		gaps_on = 0;
		random_items(ITEMS_PER_PHASE);

		start = 0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

FILE: files.f
+incdir+sv
sv/lcmlt_pkg.sv
sv/lcmlt_store.sv
sv/li_chao_max_line_tree_top.sv
sim/li_chao_max_line_tree_checker.sv
sim/tb_li_chao_max_line_tree_top.sv
